>>> sv/double_ended_queue_top_defines.svh
// Assertion macros for the double-ended queue.
// Used by files that carry concurrent checks; expects clk_i and rst_ni in scope.
`ifndef DOUBLE_ENDED_QUEUE_TOP_DEFINES_SVH
`define DOUBLE_ENDED_QUEUE_TOP_DEFINES_SVH

// Check a property at every clock edge outside reset.
`define DEQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that a condition in one cycle is followed by a consequence in the next.
`define DEQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/deq_pkg.sv
// Shared types and constants for the double-ended queue.
// No dependencies; imported by deq_cell, deq_chain and the top level.
`default_nettype none

package deq_pkg;

  localparam int DefDepth     = 16;
  localparam int DefElemWidth = 32;

  localparam int ReqW    = 3;
  localparam int StatusW = 2;
  localparam int ValueW  = 32;
  localparam int CountW  = 5;

  typedef enum logic [ReqW-1:0] {
    REQ_PUSH_FRONT = 3'd0,
    REQ_PUSH_BACK  = 3'd1,
    REQ_POP_FRONT  = 3'd2,
    REQ_POP_BACK   = 3'd3,
    REQ_PEEK_FRONT = 3'd4,
    REQ_PEEK_BACK  = 3'd5
  } req_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK    = 2'd0,
    ST_NULL  = 2'd1,
    ST_FULL  = 2'd2,
    ST_EMPTY = 2'd3
  } status_e;

  // What every cell of a chain does in one cycle.
  typedef enum logic [1:0] {
    CELL_HOLD  = 2'd0,
    CELL_PUSH  = 2'd1,  // take the neighbor nearer the head
    CELL_POP   = 2'd2,  // take the neighbor farther from the head
    CELL_WRITE = 2'd3   // the cell at the write index loads the item
  } cell_op_e;

endpackage

`default_nettype wire

>>> sv/double_ended_queue_top.sv
// Double-ended queue of element handles built from two mirrored cell chains.
// A result is registered and is valid in the cycle after its item is accepted.
// Throughput: one item per cycle; every request completes in the cycle it is accepted.
// Input stalls only while a result is held by a stalled output.
// Reset clears the internal entry count and the output valid; cell contents are undefined
// until written and need no clearing pass.
`default_nettype none
`include "double_ended_queue_top_defines.svh"

module double_ended_queue_top #(
  parameter int DEPTH      = deq_pkg::DefDepth,
  parameter int ELEM_WIDTH = deq_pkg::DefElemWidth
) (
  input  wire                           clk_i,
  input  wire                           rst_ni,
  input  wire                           in_valid_i,
  output logic                          in_stall_o,
  input  wire [deq_pkg::ReqW-1:0]       req_type_i,
  input  wire [deq_pkg::ValueW-1:0]     item_value_i,
  output logic                          out_valid_o,
  input  wire                           out_stall_i,
  output logic [deq_pkg::StatusW-1:0]   status_o,
  output logic [deq_pkg::ValueW-1:0]    out_value_o,
  output logic [deq_pkg::CountW-1:0]    entry_count_o,
  output logic                          is_empty_o
);
  import deq_pkg::*;

  localparam int CntW = $clog2(DEPTH + 1);
  localparam int InW  = (ELEM_WIDTH > ValueW) ? ELEM_WIDTH : ValueW;
  localparam int ExtW = (CntW > CountW) ? CntW : CountW;

  // The front chain keeps the front element in cell 0, the back chain the back
  // element. Each chain pushes at its own end and writes the far end by index.
  cell_op_e              front_op, back_op, front_op_d, back_op_d;
  logic [ELEM_WIDTH-1:0] elem, front_head, back_head;
  logic [InW-1:0]        item_ext, value_ext;
  logic [CntW-1:0]       cnt_q, cnt_d, cnt_next;
  logic                  in_acc, full, empty, is_push;
  status_e               st_d;
  logic [ELEM_WIDTH-1:0] value_d;

  logic                  out_valid_q;
  status_e               status_q;
  logic [ELEM_WIDTH-1:0] value_q;
  logic [CntW-1:0]       count_q;
  logic [ExtW-1:0]       count_ext;

  assign item_ext = InW'(item_value_i);
  assign elem     = item_ext[ELEM_WIDTH-1:0];
  assign full     = (cnt_q == CntW'(DEPTH));
  assign empty    = (cnt_q == '0);

  assign in_stall_o = out_valid_q && out_stall_i;
  assign in_acc     = in_valid_i && !in_stall_o;

  always_comb begin
    front_op_d = CELL_HOLD;
    back_op_d  = CELL_HOLD;
    st_d       = ST_OK;
    value_d    = '0;
    cnt_next   = cnt_q;
    is_push    = 1'b0;
    case (req_type_i)
      REQ_PUSH_FRONT, REQ_PUSH_BACK: begin
        is_push = 1'b1;
        if (elem == '0) begin
          st_d = ST_NULL;
        end else if (full) begin
          st_d = ST_FULL;
        end else begin
          cnt_next = cnt_q + 1'b1;
          if (req_type_i == REQ_PUSH_FRONT) begin
            front_op_d = CELL_PUSH;
            back_op_d  = CELL_WRITE;
          end else begin
            front_op_d = CELL_WRITE;
            back_op_d  = CELL_PUSH;
          end
        end
      end
      REQ_POP_FRONT, REQ_PEEK_FRONT: begin
        if (empty) begin
          st_d = ST_EMPTY;
        end else begin
          value_d = front_head;
          if (req_type_i == REQ_POP_FRONT) begin
            front_op_d = CELL_POP;
            cnt_next   = cnt_q - 1'b1;
          end
        end
      end
      REQ_POP_BACK, REQ_PEEK_BACK: begin
        if (empty) begin
          st_d = ST_EMPTY;
        end else begin
          value_d = back_head;
          if (req_type_i == REQ_POP_BACK) begin
            back_op_d = CELL_POP;
            cnt_next  = cnt_q - 1'b1;
          end
        end
      end
      default: begin
        st_d = ST_OK;
      end
    endcase
  end

  // Hold both chains unless an item goes in this cycle.
  assign front_op = in_acc ? front_op_d : CELL_HOLD;
  assign back_op  = in_acc ? back_op_d : CELL_HOLD;
  assign cnt_d    = in_acc ? cnt_next : cnt_q;

  deq_chain #(
    .DEPTH      (DEPTH),
    .ELEM_WIDTH (ELEM_WIDTH)
  ) u_front (
    .clk_i    (clk_i),
    .op_i     (front_op),
    .wr_idx_i (cnt_q),
    .item_i   (elem),
    .head_o   (front_head)
  );

  deq_chain #(
    .DEPTH      (DEPTH),
    .ELEM_WIDTH (ELEM_WIDTH)
  ) u_back (
    .clk_i    (clk_i),
    .op_i     (back_op),
    .wr_idx_i (cnt_q),
    .item_i   (elem),
    .head_o   (back_head)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      if (in_acc) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      status_q <= st_d;
      value_q  <= value_d;
      count_q  <= cnt_next;
    end
  end

  assign value_ext     = InW'(value_q);
  assign count_ext     = ExtW'(count_q);
  assign out_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign out_value_o   = value_ext[ValueW-1:0];
  assign entry_count_o = count_ext[CountW-1:0];
  assign is_empty_o    = (count_q == '0);

  `DEQ_ASSERT(a_cnt_bound, cnt_q <= CntW'(DEPTH), "entry count exceeds depth")
  `DEQ_ASSERT(a_single_ends, (cnt_q == CntW'(1)) |-> (front_head == back_head),
              "front and back chains disagree on a single element")
  `DEQ_ASSERT(a_no_stall_idle, !out_valid_q |-> !in_stall_o,
              "input stalled while no result is held")
  `DEQ_ASSERT_NEXT(a_push_grows, in_acc && is_push && (st_d == ST_OK),
                   cnt_q == $past(cnt_q) + 1'b1, "accepted push did not grow the count")

endmodule

`default_nettype wire

>>> sv/deq_cell.sv
// One storage cell of a deque chain: holds one element, trades with its neighbors.
// Depends on deq_pkg.
`default_nettype none

module deq_cell #(
  parameter int DEPTH      = deq_pkg::DefDepth,
  parameter int ELEM_WIDTH = deq_pkg::DefElemWidth,
  parameter int IDX        = 0
) (
  input  wire                             clk_i,
  input  wire deq_pkg::cell_op_e          op_i,
  input  wire [$clog2(DEPTH+1)-1:0]       wr_idx_i,
  input  wire [ELEM_WIDTH-1:0]            item_i,
  input  wire [ELEM_WIDTH-1:0]            prev_i,
  input  wire [ELEM_WIDTH-1:0]            next_i,
  output logic [ELEM_WIDTH-1:0]           data_o
);
  import deq_pkg::*;

  localparam int CntW = $clog2(DEPTH + 1);

  logic [ELEM_WIDTH-1:0] data_q, data_d;

  always_comb begin
    data_d = data_q;
    case (op_i)
      CELL_PUSH:  data_d = prev_i;
      CELL_POP:   data_d = next_i;
      CELL_WRITE: begin
        if (wr_idx_i == CntW'(IDX)) begin
          data_d = item_i;
        end
      end
      default:    data_d = data_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

`default_nettype wire

>>> sv/deq_chain.sv
// A row of deq_cell instances; cell 0 holds the element at this chain's end.
// Depends on deq_pkg and deq_cell.
`default_nettype none

module deq_chain #(
  parameter int DEPTH      = deq_pkg::DefDepth,
  parameter int ELEM_WIDTH = deq_pkg::DefElemWidth
) (
  input  wire                             clk_i,
  input  wire deq_pkg::cell_op_e          op_i,
  input  wire [$clog2(DEPTH+1)-1:0]       wr_idx_i,
  input  wire [ELEM_WIDTH-1:0]            item_i,
  output logic [ELEM_WIDTH-1:0]           head_o
);
  import deq_pkg::*;

  logic [ELEM_WIDTH-1:0] cell_data [DEPTH];

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [ELEM_WIDTH-1:0] prev_data, next_data;

    // Cell 0 takes the pushed item; the last cell refills from itself.
    if (i == 0) begin : g_first
      assign prev_data = item_i;
    end else begin : g_mid_prev
      assign prev_data = cell_data[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign next_data = cell_data[i];
    end else begin : g_mid_next
      assign next_data = cell_data[i+1];
    end

    deq_cell #(
      .DEPTH      (DEPTH),
      .ELEM_WIDTH (ELEM_WIDTH),
      .IDX        (i)
    ) u_cell (
      .clk_i    (clk_i),
      .op_i     (op_i),
      .wr_idx_i (wr_idx_i),
      .item_i   (item_i),
      .prev_i   (prev_data),
      .next_i   (next_data),
      .data_o   (cell_data[i])
    );
  end

  assign head_o = cell_data[0];

endmodule

`default_nettype wire
